// ===== sv/morse_code_segment_encoder_core_assert.svh =====
// Assertion macros shared by the Morse segment encoder RTL.
`ifndef MORSE_CODE_SEGMENT_ENCODER_CORE_ASSERT_SVH
`define MORSE_CODE_SEGMENT_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MCSE_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mcse assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MCSE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mcse assertion failed: next-cycle implication");

`endif

// ===== sv/mcse_pkg.sv =====
// Package for the Morse segment encoder: widths, codes, symbol tables and control store.
package mcse_pkg;

   localparam int CHAR_WIDTH      = 8;
   localparam int DUR_WIDTH       = 6;
   localparam int DASH_WIDTH      = 4;
   localparam int LGAP_WIDTH      = 4;
   localparam int WGAP_WIDTH      = 5;
   localparam int PAUSE_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam int PC_WIDTH        = 3;
   localparam int COUNT_WIDTH     = 3;
   localparam int PATTERN_WIDTH   = 5;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DASH_UNITS       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LETTER_GAP_UNITS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WORD_GAP_UNITS   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_END_PAUSE_UNITS  = 2'd3;

   localparam logic [DASH_WIDTH-1:0]  RESET_DASH_UNITS       = 4'd3;
   localparam logic [LGAP_WIDTH-1:0]  RESET_LETTER_GAP_UNITS = 4'd2;
   localparam logic [WGAP_WIDTH-1:0]  RESET_WORD_GAP_UNITS   = 5'd4;
   localparam logic [PAUSE_WIDTH-1:0] RESET_END_PAUSE_UNITS  = 6'd25;

   // Character classes
   localparam logic [1:0] CLS_NONE   = 2'd0;
   localparam logic [1:0] CLS_SPACE  = 2'd1;
   localparam logic [1:0] CLS_SYMBOL = 2'd2;

   // Program step addresses
   localparam logic [PC_WIDTH-1:0] S_DISPATCH = 3'd0;
   localparam logic [PC_WIDTH-1:0] S_SYM_ON   = 3'd1;
   localparam logic [PC_WIDTH-1:0] S_SYM_OFF  = 3'd2;
   localparam logic [PC_WIDTH-1:0] S_LGAP     = 3'd3;
   localparam logic [PC_WIDTH-1:0] S_WORD     = 3'd4;
   localparam logic [PC_WIDTH-1:0] S_PAUSE    = 3'd5;

   // Segment selects
   localparam logic [2:0] SEG_NONE     = 3'd0;
   localparam logic [2:0] SEG_SYMBOL   = 3'd1;
   localparam logic [2:0] SEG_UNIT_OFF = 3'd2;
   localparam logic [2:0] SEG_LGAP     = 3'd3;
   localparam logic [2:0] SEG_WGAP     = 3'd4;
   localparam logic [2:0] SEG_PAUSE    = 3'd5;

   // Jump conditions
   localparam logic [2:0] J_NEXT   = 3'd0;
   localparam logic [2:0] J_CLASS  = 3'd1;
   localparam logic [2:0] J_MORE   = 3'd2;
   localparam logic [2:0] J_TARGET = 3'd3;
   localparam logic [2:0] J_END    = 3'd4;

   // Last-segment rules
   localparam logic [1:0] LAST_NEVER    = 2'd0;
   localparam logic [1:0] LAST_SYM_TAIL = 2'd1;
   localparam logic [1:0] LAST_TAIL     = 2'd2;
   localparam logic [1:0] LAST_ALWAYS   = 2'd3;

   typedef struct packed {
      logic [2:0]          seg_sel;
      logic [2:0]          jump;
      logic [PC_WIDTH-1:0] target;
      logic [1:0]          last_rule;
      logic                shift_symbol;
   } ucode_type;

   typedef struct packed {
      logic [1:0]               cls;
      logic [COUNT_WIDTH-1:0]   len;
      logic [PATTERN_WIDTH-1:0] pattern;
   } char_info_type;

   // Symbol patterns: first symbol in bit 0, 1 means dash.
   localparam logic [COUNT_WIDTH-1:0] LETTER_LEN [26] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };
   localparam logic [PATTERN_WIDTH-1:0] LETTER_BITS [26] = '{
      5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E, 5'h05,
      5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01, 5'h04, 5'h08,
      5'h06, 5'h09, 5'h0D, 5'h03
   };
   localparam logic [PATTERN_WIDTH-1:0] DIGIT_BITS [10] = '{
      5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
   };

   function automatic char_info_type classify(input logic [CHAR_WIDTH-1:0] code);
      logic [CHAR_WIDTH-1:0] upper;
      logic [CHAR_WIDTH-1:0] offset;
      char_info_type         info;
      upper        = code;
      info.cls     = CLS_NONE;
      info.len     = '0;
      info.pattern = '0;
      if (code >= 8'h61 && code <= 8'h7A) begin
         upper = code & 8'hDF;
      end
      if (upper >= 8'h41 && upper <= 8'h5A) begin
         offset       = upper - 8'h41;
         info.cls     = CLS_SYMBOL;
         info.len     = LETTER_LEN[offset[4:0]];
         info.pattern = LETTER_BITS[offset[4:0]];
      end else if (upper >= 8'h30 && upper <= 8'h39) begin
         offset       = upper - 8'h30;
         info.cls     = CLS_SYMBOL;
         info.len     = 3'd5;
         info.pattern = DIGIT_BITS[offset[3:0]];
      end else if (upper == 8'h20) begin
         info.cls = CLS_SPACE;
      end
      return info;
   endfunction

   // Control store
   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ucode_type w;
      case (pc)
         S_DISPATCH: w = '{SEG_NONE,     J_CLASS,  S_DISPATCH, LAST_NEVER,    1'b0};
         S_SYM_ON:   w = '{SEG_SYMBOL,   J_NEXT,   S_DISPATCH, LAST_NEVER,    1'b0};
         S_SYM_OFF:  w = '{SEG_UNIT_OFF, J_MORE,   S_SYM_ON,   LAST_SYM_TAIL, 1'b1};
         S_LGAP:     w = '{SEG_LGAP,     J_TARGET, S_PAUSE,    LAST_TAIL,     1'b0};
         S_WORD:     w = '{SEG_WGAP,     J_NEXT,   S_DISPATCH, LAST_TAIL,     1'b0};
         S_PAUSE:    w = '{SEG_PAUSE,    J_END,    S_DISPATCH, LAST_ALWAYS,   1'b0};
         default:    w = '{SEG_NONE,     J_END,    S_DISPATCH, LAST_NEVER,    1'b0};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/morse_code_segment_encoder_core.sv =====
// Morse segment encoder: microcoded sequencer expanding one character into LED segments.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    char_code, end_of_message
//   rsp      out        rsp_valid/stall    led_on, duration_units, last_segment
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// The step counter walks the control store one step per cycle unless rsp stalls it. A
// character takes dispatch, an on and an off step per symbol, letter gap and pause; a space
// takes dispatch, word gap and pause; an unknown code dispatch and pause. Stalls on rsp hold
// the sequencer at an emitting step. req_stall stays high while a character is being expanded.
// Reset is synchronous; it clears the sequencer and the output valid and loads the registers' reset values.
`include "morse_code_segment_encoder_core_assert.svh"

module morse_code_segment_encoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mcse_pkg::CHAR_WIDTH-1:0]      req_char_code,
   input  logic                                 req_end_of_message,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_led_on,
   output logic [mcse_pkg::DUR_WIDTH-1:0]       rsp_duration_units,
   output logic                                 rsp_last_segment,
   input  logic                                 csr_write_enable,
   input  logic [mcse_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mcse_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import mcse_pkg::*;

   logic [DASH_WIDTH-1:0]    dash_ff,  dash_in;
   logic [LGAP_WIDTH-1:0]    lgap_ff,  lgap_in;
   logic [WGAP_WIDTH-1:0]    wgap_ff,  wgap_in;
   logic [PAUSE_WIDTH-1:0]   pause_ff, pause_in;

   logic                     busy_ff,  busy_in;
   logic [PC_WIDTH-1:0]      pc_ff,    pc_in;
   logic [1:0]               cls_ff,   cls_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [PATTERN_WIDTH-1:0] pat_ff,   pat_in;
   logic                     eom_ff,   eom_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     led_ff,   led_in;
   logic [DUR_WIDTH-1:0]     dur_ff,   dur_in;
   logic                     last_ff,  last_in;

   ucode_type                uw;
   char_info_type            info;
   logic                     req_xfer;
   logic                     pause_due;
   logic                     want_emit;
   logic                     step_go;
   logic                     seg_led;
   logic [DUR_WIDTH-1:0]     seg_dur;
   logic                     seg_last;

   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !busy_ff;
   assign info      = classify(req_char_code);
   assign uw        = ucode_rom(pc_ff);
   assign pause_due = eom_ff && (pause_ff != '0);

   // Decode the current control word into a segment
   always_comb begin
      want_emit = 1'b0;
      seg_led   = 1'b0;
      seg_dur   = '0;
      case (uw.seg_sel)
         SEG_SYMBOL: begin
            want_emit = 1'b1;
            seg_led   = 1'b1;
            seg_dur   = pat_ff[0] ? DUR_WIDTH'(dash_ff) : DUR_WIDTH'(1);
         end
         SEG_UNIT_OFF: begin
            want_emit = 1'b1;
            seg_dur   = DUR_WIDTH'(1);
         end
         SEG_LGAP: begin
            want_emit = (lgap_ff != '0);
            seg_dur   = DUR_WIDTH'(lgap_ff);
         end
         SEG_WGAP: begin
            want_emit = (wgap_ff != '0);
            seg_dur   = DUR_WIDTH'(wgap_ff);
         end
         SEG_PAUSE: begin
            want_emit = pause_due;
            seg_dur   = pause_ff;
         end
         default: begin
            want_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (uw.last_rule)
         LAST_SYM_TAIL: seg_last = (count_ff == COUNT_WIDTH'(1)) && (lgap_ff == '0) && !pause_due;
         LAST_TAIL:     seg_last = !pause_due;
         LAST_ALWAYS:   seg_last = 1'b1;
         default:       seg_last = 1'b0;
      endcase
   end

   // Advance while busy unless the step must emit and the output register is full and stalled
   assign step_go = busy_ff && (!want_emit || !rsp_valid_ff || !rsp_stall);

   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      cls_in   = cls_ff;
      count_in = count_ff;
      pat_in   = pat_ff;
      eom_in   = eom_ff;
      if (req_xfer) begin
         busy_in  = 1'b1;
         pc_in    = S_DISPATCH;
         cls_in   = info.cls;
         count_in = info.len;
         pat_in   = info.pattern;
         eom_in   = req_end_of_message;
      end else if (step_go) begin
         if (uw.shift_symbol) begin
            count_in = count_ff - COUNT_WIDTH'(1);
            pat_in   = pat_ff >> 1;
         end
         case (uw.jump)
            J_NEXT:   pc_in = pc_ff + PC_WIDTH'(1);
            J_TARGET: pc_in = uw.target;
            J_MORE:   pc_in = (count_ff != COUNT_WIDTH'(1)) ? uw.target : pc_ff + PC_WIDTH'(1);
            J_CLASS: begin
               case (cls_ff)
                  CLS_SYMBOL: pc_in = S_SYM_ON;
                  CLS_SPACE:  pc_in = S_WORD;
                  default:    pc_in = S_PAUSE;
               endcase
            end
            J_END:    busy_in = 1'b0;
            default:  busy_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      led_in       = led_ff;
      dur_in       = dur_ff;
      last_in      = last_ff;
      if (step_go && want_emit) begin
         rsp_valid_in = 1'b1;
         led_in       = seg_led;
         dur_in       = seg_dur;
         last_in      = seg_last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      dash_in  = dash_ff;
      lgap_in  = lgap_ff;
      wgap_in  = wgap_ff;
      pause_in = pause_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_DASH_UNITS:       dash_in  = csr_write_data[DASH_WIDTH-1:0];
            REG_LETTER_GAP_UNITS: lgap_in  = csr_write_data[LGAP_WIDTH-1:0];
            REG_WORD_GAP_UNITS:   wgap_in  = csr_write_data[WGAP_WIDTH-1:0];
            REG_END_PAUSE_UNITS:  pause_in = csr_write_data[PAUSE_WIDTH-1:0];
            default: begin
               dash_in = dash_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_ff      <= RESET_DASH_UNITS;
         lgap_ff      <= RESET_LETTER_GAP_UNITS;
         wgap_ff      <= RESET_WORD_GAP_UNITS;
         pause_ff     <= RESET_END_PAUSE_UNITS;
         busy_ff      <= 1'b0;
         pc_ff        <= S_DISPATCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         dash_ff      <= dash_in;
         lgap_ff      <= lgap_in;
         wgap_ff      <= wgap_in;
         pause_ff     <= pause_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff   <= cls_in;
      count_ff <= count_in;
      pat_ff   <= pat_in;
      eom_ff   <= eom_in;
      led_ff   <= led_in;
      dur_ff   <= dur_in;
      last_ff  <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_led_on         = led_ff;
   assign rsp_duration_units = dur_ff;
   assign rsp_last_segment   = last_ff;

   `MCSE_ASSERT_NEXT(a_accept_starts_dispatch, clock, reset, req_xfer, busy_ff && pc_ff == S_DISPATCH)
   `MCSE_ASSERT_IMP(a_symbol_count_nonzero, clock, reset, busy_ff && (pc_ff == S_SYM_ON || pc_ff == S_SYM_OFF), count_ff != '0)
   `MCSE_ASSERT_IMP(a_lit_never_last, clock, reset, rsp_valid_ff && led_ff, !last_ff)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Morse segment encoder core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcse_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 48;

   typedef struct {
      logic [CHAR_WIDTH-1:0] code;
      logic                  eom;
   } char_item_type;

   typedef struct {
      logic                 led_on;
      logic [DUR_WIDTH-1:0] duration;
      logic                 last;
   } segment_type;

   // Dots and dashes, first symbol leftmost
   string morse_letters [26] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---", "-.-",
      ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-", "...-",
      ".--", "-..-", "-.--", "--.."
   };
   string morse_digits [10] = '{
      "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
      "---..", "----."
   };

   localparam logic [CHAR_WIDTH-1:0] DIRECTED_CODES [20] = '{
      8'h41, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60,
      8'h7B, 8'h2F, 8'h3A, 8'h80, 8'h51, 8'h20, 8'h61, 8'h45, 8'h54, 8'h59
   };
   localparam bit DIRECTED_EOM [20] = '{
      0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 0, 0, 1
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [CHAR_WIDTH-1:0]      req_char_code = '0;
   logic                       req_end_of_message = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_led_on;
   logic [DUR_WIDTH-1:0]       rsp_duration_units;
   logic                       rsp_last_segment;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Register copies, reset values of the block
   logic [DASH_WIDTH-1:0]  dash_len   = 4'd3;
   logic [LGAP_WIDTH-1:0]  letter_gap = 4'd2;
   logic [WGAP_WIDTH-1:0]  word_gap   = 5'd4;
   logic [PAUSE_WIDTH-1:0] end_pause  = 6'd25;

   char_item_type pending_chars [$];
   segment_type   expected_segments [$];
   char_item_type driven_char;
   segment_type   seen_segment;
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            error_count = 0;
   int            cycle_count = 0;

   morse_code_segment_encoder_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, what);
   endtask

   task automatic push_segment(input logic on, input logic [DUR_WIDTH-1:0] duration);
      expected_segments.push_back('{on, duration, 1'b0});
   endtask

   // Expand one character into its segments using the current register copies
   task automatic expand_morse(input logic [CHAR_WIDTH-1:0] code, input logic eom);
      logic [CHAR_WIDTH-1:0] upper;
      string                 pattern;
      int                    first;
      first   = expected_segments.size();
      upper   = code;
      pattern = "";
      if (code >= 8'h61 && code <= 8'h7A) begin
         upper = code - 8'h20;
      end
      if (upper >= 8'h41 && upper <= 8'h5A) begin
         pattern = morse_letters[upper - 8'h41];
      end else if (upper >= 8'h30 && upper <= 8'h39) begin
         pattern = morse_digits[upper - 8'h30];
      end else if (upper == 8'h20 && word_gap != 0) begin
         push_segment(1'b0, DUR_WIDTH'(word_gap));
      end
      for (int i = 0; i < pattern.len(); i++) begin
         push_segment(1'b1, (pattern[i] == "-") ? DUR_WIDTH'(dash_len) : DUR_WIDTH'(1));
         push_segment(1'b0, DUR_WIDTH'(1));
      end
      if (pattern.len() != 0 && letter_gap != 0) begin
         push_segment(1'b0, DUR_WIDTH'(letter_gap));
      end
      if (eom && end_pause != 0) begin
         push_segment(1'b0, end_pause);
      end
      if (expected_segments.size() > first) begin
         expected_segments[$].last = 1'b1;
      end
   endtask

   // Driver: hold a stalled transfer, otherwise offer the next pending character
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
      end else if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         driven_char = pending_chars.pop_front();
         req_valid          <= 1'b1;
         req_char_code      <= driven_char.code;
         req_end_of_message <= driven_char.eom;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expand_morse(req_char_code, req_end_of_message);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_segments.size() == 0) begin
               report_mismatch($sformatf("unexpected segment led=%0b dur=%0d last=%0b",
                  rsp_led_on, rsp_duration_units, rsp_last_segment));
            end else begin
               seen_segment = expected_segments.pop_front();
               if (rsp_led_on !== seen_segment.led_on) begin
                  report_mismatch($sformatf("led_on %0b, expected %0b",
                     rsp_led_on, seen_segment.led_on));
               end
               if (rsp_duration_units !== seen_segment.duration) begin
                  report_mismatch($sformatf("duration_units %0d, expected %0d",
                     rsp_duration_units, seen_segment.duration));
               end
               if (rsp_last_segment !== seen_segment.last) begin
                  report_mismatch($sformatf("last_segment %0b, expected %0b",
                     rsp_last_segment, seen_segment.last));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d segments outstanding", expected_segments.size());
         $display("morse_code_segment_encoder_core verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         REG_DASH_UNITS:       dash_len   = data[DASH_WIDTH-1:0];
         REG_LETTER_GAP_UNITS: letter_gap = data[LGAP_WIDTH-1:0];
         REG_WORD_GAP_UNITS:   word_gap   = data[WGAP_WIDTH-1:0];
         REG_END_PAUSE_UNITS:  end_pause  = data[PAUSE_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_WIDTH-1:0] dash, lgap, wgap, pause);
      write_reg(REG_DASH_UNITS, dash);
      write_reg(REG_LETTER_GAP_UNITS, lgap);
      write_reg(REG_WORD_GAP_UNITS, wgap);
      write_reg(REG_END_PAUSE_UNITS, pause);
      @(negedge clock);
   endtask

   // Wait for every result, then let an ignored character finish
   task automatic wait_drained;
      do begin
         @(negedge clock);
      end while (pending_chars.size() != 0 || req_valid || expected_segments.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed messages, with some stray codes and broken framing
   task automatic queue_messages(input int count);
      int                    queued;
      int                    msg_len;
      int                    pick;
      logic [CHAR_WIDTH-1:0] code;
      logic                  eom;
      queued = 0;
      while (queued < count) begin
         msg_len = $urandom_range(1, 8);
         for (int j = 0; j < msg_len; j++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               code = 8'(8'h41 + $urandom_range(25));
            end else if (pick < 45) begin
               code = 8'(8'h61 + $urandom_range(25));
            end else if (pick < 62) begin
               code = 8'(8'h30 + $urandom_range(9));
            end else if (pick < 77) begin
               code = 8'h20;
            end else begin
               code = 8'($urandom_range(255));
            end
            eom = (j == msg_len - 1);
            if ($urandom_range(19) == 0) begin
               eom = !eom;
            end
            pending_chars.push_back('{code, eom});
            queued++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int k = 0; k < 20; k++) begin
         pending_chars.push_back('{DIRECTED_CODES[k], DIRECTED_EOM[k]});
      end
      wait_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: apply_settings(6'd15, 6'd15, 6'd31, 6'd63);
            1: apply_settings(6'd0, 6'd0, 6'd0, 6'd0);
            2: apply_settings(6'd1, 6'd1, 6'd1, 6'd1);
            // upper data bits set: only the register's own width must land
            4: apply_settings(6'h35, 6'h3A, 6'h2F, 6'h3F);
            5: apply_settings(6'd3, 6'd2, 6'd4, 6'd25);
            default: apply_settings(6'($urandom_range(63)), 6'($urandom_range(63)),
                                    6'($urandom_range(63)), 6'($urandom_range(63)));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         if (phase == 2) begin
            // hold off the sender until the receiver has caught up
            queue_messages(PHASE_ITEMS / 2);
            wait_drained();
            queue_messages(PHASE_ITEMS / 2);
         end else begin
            queue_messages(PHASE_ITEMS);
         end
         wait_drained();
      end

      if (error_count == 0) begin
         $display("morse_code_segment_encoder_core verification clean");
      end else begin
         $display("morse_code_segment_encoder_core verification failed");
      end
      $finish;
   end

endmodule

// ===== morse_code_segment_encoder_core.f =====
+incdir+sv
sv/mcse_pkg.sv
sv/morse_code_segment_encoder_core.sv
verif/tb.sv
